>>> design/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg: shared types and constants of the frame rate meter
// Field widths, register indexes, divider sizing and sequencer states.
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int STAMP_W   = 64;
    localparam int RATE_W    = 36;
    localparam int ALPHA_W   = 16;
    localparam int TICKS_W   = 24;
    localparam int COUNT_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = TICKS_W + FRAC_W;    // dividend width
    localparam int STEP_W    = $clog2(NUM_W);       // divider step counter
    localparam int PROD_W    = RATE_W + FRAC_W + 2; // signed blend product / accumulator
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam logic [RATE_W-1:0]    RATE_MAX    = {RATE_W{1'b1}};
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET = ALPHA_W'(3277);
    localparam logic [TICKS_W-1:0]   TICKS_RESET = TICKS_W'(1000000);

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS   = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quo;
    } t_div_res;

endpackage

>>> design/frame_rate_ewma_meter.sv
// ----------------------------------------------------------------------------
// frame_rate_ewma_meter: frame rate meter with exponential smoothing
// Per frame event: instant rate ticks_per_second*65536/delta in Q20.16,
// smoothed rate (alpha*instant + (1-alpha)*smoothed) and a frame count.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------
//  input    | in        | i_valid / o_stall         | i_timestamp
//  result   | out       | o_valid / i_stall         | o_smoothed_rate, o_instant_rate,
//           |           |                           | o_frames_seen
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Divider: a regular frame runs through the restoring divider (one quotient
//  bit per cycle over a 40-bit dividend) between accept and result. A first
//  frame or a non-positive delta skips the divider.
//  Reset: synchronous, active low; clears stamp, rates and count, restores registers.
//  Stalls: o_stall is high while a frame is in work. The result register holds
//  one beat; a finished frame waits in ST_OUT until that register is free.
// ----------------------------------------------------------------------------
module frame_rate_ewma_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beats
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [frm_pkg::STAMP_W-1:0]   i_timestamp,
    // result beats
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [frm_pkg::RATE_W-1:0]    o_smoothed_rate,
    output logic [frm_pkg::RATE_W-1:0]    o_instant_rate,
    output logic [frm_pkg::COUNT_W-1:0]   o_frames_seen,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [frm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [frm_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import frm_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [ALPHA_W-1:0]  r_alpha;
    logic [TICKS_W-1:0]  r_ticks;

    // meter state
    logic [STAMP_W-1:0]  r_last;
    logic [STAMP_W-1:0]  r_now;
    logic [RATE_W-1:0]   r_smooth;
    logic [RATE_W-1:0]   r_inst;
    logic [COUNT_W-1:0]  r_count;
    logic                r_first;
    logic signed [PROD_W-1:0] r_prod;

    // result register
    logic                r_out_valid;
    logic [RATE_W-1:0]   r_out_smooth;
    logic [RATE_W-1:0]   r_out_inst;
    logic [COUNT_W-1:0]  r_out_count;

    logic                w_accept;
    logic                w_out_free;
    logic [STAMP_W-1:0]  w_delta;
    logic                w_delta_pos;
    logic                w_div_start;
    logic                w_load_out;
    logic signed [RATE_W:0]   w_gap;
    logic signed [PROD_W-1:0] w_mul;
    logic signed [PROD_W-1:0] w_acc;
    t_div_res            w_div;

    assign w_accept    = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_delta     = r_now - r_last;
    assign w_delta_pos = (w_delta != '0) && !w_delta[STAMP_W-1];

    // EWMA as smooth + alpha*(instant - smooth); alpha zero-extended to signed
    assign w_gap = $signed({1'b0, r_inst}) - $signed({1'b0, r_smooth});
    assign w_mul = PROD_W'($signed({1'b0, r_alpha})) * PROD_W'(w_gap);
    assign w_acc = $signed({2'b00, r_smooth, {FRAC_W{1'b0}}}) + r_prod;

    frm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_ticks, {FRAC_W{1'b0}}}),
        .i_den   (w_delta),
        .o_res   (w_div)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_stall     = 1'b1;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = (r_last == '0) ? ST_OUT : ST_DELTA;
                end
            end
            ST_DELTA: begin
                w_div_start = w_delta_pos;
                n_state     = w_delta_pos ? ST_DIV : ST_MUL;
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = (r_smooth == '0) ? ST_OUT : ST_ADD;
            end
            ST_ADD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state: config, stored stamp, rates, count, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RESET;
            r_ticks     <= TICKS_RESET;
            r_last      <= '0;
            r_smooth    <= '0;
            r_inst      <= '0;
            r_count     <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                    CFG_TICKS: r_ticks <= i_cfg_data[TICKS_W-1:0];
                    default:   ;
                endcase
            end

            if (w_accept) begin
                r_count <= r_count + 1'b1;
                r_first <= (r_last == '0);
                if (r_last == '0) begin
                    r_last <= i_timestamp;   // first frame only records time
                end
            end

            if (r_state == ST_DELTA) begin
                r_last <= r_now;
            end

            if (r_state == ST_DIV && w_div.done) begin
                r_inst <= w_div.quo;
            end

            // zero smoothed value reseeds from the instant rate
            if (r_state == ST_MUL && r_smooth == '0) begin
                r_smooth <= r_inst;
            end

            if (r_state == ST_ADD) begin
                r_smooth <= w_acc[RATE_W+FRAC_W-1:FRAC_W];
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now <= i_timestamp;
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_mul;
        end
        if (w_load_out) begin
            r_out_smooth <= r_first ? '0 : r_smooth;
            r_out_inst   <= r_inst;
            r_out_count  <= r_count;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_smoothed_rate = r_out_smooth;
    assign o_instant_rate  = r_out_inst;
    assign o_frames_seen   = r_out_count;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("input accepted again before frame finished");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the division state");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && i_stall) |=> (r_state == ST_OUT))
        else $error("finished frame left while result register was full");

    a_blend_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |-> (r_smooth != '0))
        else $error("blend step entered with zero smoothed value");

endmodule

>>> design/frm_div.sv
// ----------------------------------------------------------------------------
// frm_div: iterative restoring divider
// One quotient bit per cycle, NUM_W quotient bits in all; quotient saturates at RATE_MAX.
// ----------------------------------------------------------------------------
module frm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [frm_pkg::NUM_W-1:0]  i_num,
    input  logic [frm_pkg::STAMP_W-1:0] i_den,
    output frm_pkg::t_div_res          o_res
);
    import frm_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [NUM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_quo;
    logic [STAMP_W-1:0] r_den;

    logic [NUM_W:0]     w_shift;
    logic [NUM_W:0]     w_diff;
    logic               w_ge;

    // remainder stays below 2^NUM_W, so the shifted value has NUM_W+1 bits
    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = {{(STAMP_W-NUM_W-1){1'b0}}, w_shift} >= r_den;
    assign w_diff  = w_shift - r_den[NUM_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[NUM_W-1:0] : w_shift[NUM_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = (r_quo[NUM_W-1:RATE_W] != '0) ? RATE_MAX : r_quo[RATE_W-1:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider restarted while busy");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({{(STAMP_W-NUM_W){1'b0}}, r_rem} < r_den))
        else $error("divider remainder not below divisor");

endmodule
